FILE: sv/rcfg_pkg.sv
// Shared constants, types and the CRC helper for the RC channel frame generator.
// Depends on nothing; every other file but rcfg_scale refers to it by scoped names.
`default_nettype none

package rcfg_pkg;

    localparam int unsigned SAFE_FRAMES = 5;
    localparam logic [2:0] SAFE_FRAMES_CNT = 3'(SAFE_FRAMES);

    localparam int unsigned CH_BITS = 11;
    localparam int unsigned NUM_VAR_CH = 7;

    localparam logic [CH_BITS-1:0] CH_MIN = 11'd172;
    localparam logic [CH_BITS-1:0] CH_MID = 11'd992;
    localparam logic [CH_BITS-1:0] CH_MAX = 11'd1811;
    localparam logic [CH_BITS-1:0] BTN_BIAS = 11'd200;

    localparam logic [CH_BITS-1:0] COEF_THR = 11'd1639;
    localparam logic [CH_BITS-1:0] COEF_YAW_POS = 11'd819;
    localparam logic [CH_BITS-1:0] COEF_YAW_NEG = 11'd820;

    localparam logic [7:0] BYTE_SYNC = 8'hC8;
    localparam logic [7:0] BYTE_LEN = 8'd24;
    localparam logic [7:0] BYTE_TYPE = 8'h16;
    localparam logic [7:0] CRC_POLY = 8'hD5;

    localparam logic CMD_CONTROL = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic CFG_OUTPUT_PERIOD = 1'b0;
    localparam logic CFG_FAILSAFE_TIMEOUT = 1'b1;

    typedef logic [NUM_VAR_CH-1:0][CH_BITS-1:0] t_chan_vals;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/rcfg_scale.sv
// Serial scaler: multiplies a 15-bit magnitude by an 11-bit coefficient one
// multiplier bit per cycle, then divides by 32767. Depends on nothing.
`default_nettype none

module rcfg_scale (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [14:0] i_mag,
    input  wire logic [10:0] i_coef,
    output logic      [10:0] o_quot,
    output logic             o_done
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL = 2'd1;
    localparam logic [1:0] PH_DIV = 2'd2;
    localparam logic [3:0] LAST_STEP = 4'd14;
    localparam logic [15:0] DIV_K = 16'd32767;

    logic [1:0]  r_phase;
    logic [3:0]  r_cnt;
    logic [14:0] r_mag;
    logic [25:0] r_mul;
    logic [25:0] r_acc;
    logic [10:0] r_quot;
    logic        r_done;

    logic [10:0] n_q0;
    logic [15:0] n_rem;
    logic [10:0] n_quot;

    // The quotient by 2^15 undershoots the quotient by 2^15-1 by at most one.
    always_comb begin
        n_q0 = r_acc[25:15];
        n_rem = {1'b0, r_acc[14:0]} + {5'b0, n_q0};
        n_quot = n_q0 + {10'b0, (n_rem >= DIV_K)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_mag <= i_mag;
                        r_mul <= {15'b0, i_coef};
                        r_acc <= '0;
                        r_cnt <= '0;
                        r_phase <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    if (r_mag[0]) begin
                        r_acc <= r_acc + r_mul;
                    end
                    r_mag <= {1'b0, r_mag[14:1]};
                    r_mul <= {r_mul[24:0], 1'b0};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == LAST_STEP) begin
                        r_phase <= PH_DIV;
                    end
                end
                PH_DIV: begin
                    r_quot <= n_quot;
                    r_done <= 1'b1;
                    r_phase <= PH_IDLE;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

`ifndef SYNTHESIS
    a_done_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DIV) |=> (r_done && r_phase == PH_IDLE))
        else $error("scaler did not finish after the divide step");
    a_mul_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MUL) |-> (r_cnt <= LAST_STEP))
        else $error("scaler step count overran");
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_quot <= 11'd1639))
        else $error("scaled value out of range");
`endif

endmodule

`default_nettype wire

FILE: sv/rcfg_packer.sv
// Frame packer: builds the 26-byte channel frame, shifting one channel bit per
// cycle into each payload byte, appends the CRC and holds the output register. Uses rcfg_pkg.
`default_nettype none

module rcfg_packer (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire rcfg_pkg::t_chan_vals  i_chan,
    input  wire logic                  i_stall,
    output logic                       o_valid,
    output logic [7:0]                 o_frame_byte,
    output logic                       o_last_byte,
    output logic                       o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PUT = 2'd1;
    localparam logic [1:0] S_BUILD = 2'd2;

    localparam logic [4:0] IDX_SYNC = 5'd0;
    localparam logic [4:0] IDX_LEN = 5'd1;
    localparam logic [4:0] IDX_TYPE = 5'd2;
    localparam logic [4:0] IDX_FIRST_PAY = 5'd3;
    localparam logic [4:0] IDX_LAST_PAY = 5'd24;
    localparam logic [4:0] IDX_CRC = 5'd25;
    localparam logic [3:0] LAST_CH_BIT = 4'd10;
    localparam logic [3:0] NUM_VAR = 4'(rcfg_pkg::NUM_VAR_CH);

    logic [1:0] r_state;
    logic [4:0] r_idx;
    logic [3:0] r_ch;
    logic [3:0] r_bit;
    logic [2:0] r_bcnt;
    logic [7:0] r_shift;
    logic [7:0] r_crc;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;

    logic                          n_out_free;
    logic [rcfg_pkg::CH_BITS-1:0]  n_ch_val;
    logic                          n_cur_bit;
    logic [7:0]                    n_put_byte;
    logic [4:0]                    n_idx;

    always_comb begin
        n_out_free = !r_ovalid || !i_stall;
        n_ch_val = (r_ch < NUM_VAR) ? i_chan[r_ch[2:0]] : rcfg_pkg::CH_MIN;
        n_cur_bit = n_ch_val[r_bit];
        n_idx = r_idx + 5'd1;
        case (r_idx)
            IDX_SYNC: n_put_byte = rcfg_pkg::BYTE_SYNC;
            IDX_LEN:  n_put_byte = rcfg_pkg::BYTE_LEN;
            IDX_TYPE: n_put_byte = rcfg_pkg::BYTE_TYPE;
            IDX_CRC:  n_put_byte = r_crc;
            default:  n_put_byte = r_shift;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_idx <= IDX_SYNC;
                        r_crc <= '0;
                        r_ch <= '0;
                        r_bit <= '0;
                        r_bcnt <= '0;
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (n_out_free) begin
                        r_ovalid <= 1'b1;
                        r_obyte <= n_put_byte;
                        r_olast <= (r_idx == IDX_CRC);
                        if (r_idx inside {[IDX_TYPE:IDX_LAST_PAY]}) begin
                            r_crc <= rcfg_pkg::crc_step(r_crc, n_put_byte);
                        end
                        r_idx <= n_idx;
                        if (r_idx == IDX_CRC) begin
                            r_state <= S_IDLE;
                        end else if (n_idx inside {[IDX_FIRST_PAY:IDX_LAST_PAY]}) begin
                            r_state <= S_BUILD;
                        end
                    end
                end
                S_BUILD: begin
                    r_shift <= {n_cur_bit, r_shift[7:1]};
                    if (r_bit == LAST_CH_BIT) begin
                        r_bit <= '0;
                        r_ch <= r_ch + 4'd1;
                    end else begin
                        r_bit <= r_bit + 4'd1;
                    end
                    r_bcnt <= r_bcnt + 3'd1;
                    if (r_bcnt == 3'd7) begin
                        r_state <= S_PUT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_frame_byte = r_obyte;
    assign o_last_byte = r_olast;
    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_build_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUILD) |-> (r_idx >= IDX_FIRST_PAY && r_idx <= IDX_LAST_PAY))
        else $error("payload bits shifted outside the payload bytes");
    a_crc_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && n_out_free && r_idx == IDX_CRC) |=>
            (r_state == S_IDLE && r_ovalid && r_olast))
        else $error("CRC byte did not close the frame");
    a_payload_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && r_idx == IDX_CRC) |-> (r_ch == 4'd0 && r_bit == 4'd0))
        else $error("channel bits did not fill the payload exactly");
`endif

endmodule

`default_nettype wire

FILE: sv/rc_channel_frame_generator.sv
// Top level of the RC channel frame generator: control state, failsafe logic and
// configuration. Instantiates rcfg_scale twice and rcfg_packer; uses rcfg_pkg.
//
//   channel | valid   | stall   | payload
//   input   | i_valid | o_stall | i_cmd, i_buttons, i_throttle_axis, i_yaw_axis
//   output  | o_valid | i_stall | o_frame_byte, o_last_byte
//   config  | i_cfg_we| -       | i_cfg_index, i_cfg_data
//
// Each payload byte is built one channel bit per cycle, and a normal frame first waits
// for the serial axis scalers, which a safe frame does not use.
// The input is stalled while a frame is in work, up to loading of its last byte.
// Reset is synchronous and restores all control state and the register defaults.
`default_nettype none

module rc_channel_frame_generator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_cmd,
    input  wire logic [6:0]  i_buttons,
    input  wire logic [15:0] i_throttle_axis,
    input  wire logic [15:0] i_yaw_axis,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_frame_byte,
    output logic             o_last_byte,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_MUL_GO = 2'd1;
    localparam logic [1:0] T_MUL_WAIT = 2'd2;
    localparam logic [1:0] T_LAUNCH = 2'd3;

    logic [9:0]  r_period;
    logic [15:0] r_timeout;
    logic [6:0]  r_buttons;
    logic [15:0] r_throttle;
    logic [15:0] r_yaw;
    logic [2:0]  r_prev_latch;
    logic [2:0]  r_latch;
    logic        r_seen;
    logic        r_link_lost;
    logic [15:0] r_age;
    logic [9:0]  r_pc;
    logic        r_silent;
    logic [2:0]  r_sfl;
    logic [1:0]  r_state;
    rcfg_pkg::t_chan_vals r_chan;

    logic        n_accept;
    logic [15:0] n_age;
    logic [9:0]  n_pc;
    logic        n_decide;
    logic        n_fresh;
    logic [2:0]  n_sfl;
    logic        n_thr_pos;
    logic        n_yaw_neg;
    logic [15:0] n_yaw_abs;
    logic [10:0] n_yaw_coef;
    logic [10:0] w_thr_q;
    logic [10:0] w_yaw_q;
    logic        w_thr_done;
    logic        w_yaw_done;
    logic        w_pk_busy;
    rcfg_pkg::t_chan_vals n_fresh_chan;
    rcfg_pkg::t_chan_vals n_safe_chan;

    function automatic logic [10:0] button_axis(input logic lo, input logic hi);
        if (lo == hi) begin
            return rcfg_pkg::CH_MID;
        end
        return hi ? (rcfg_pkg::CH_MID + rcfg_pkg::BTN_BIAS)
                  : (rcfg_pkg::CH_MID - rcfg_pkg::BTN_BIAS);
    endfunction

    always_comb begin
        o_stall = (r_state != T_IDLE) || w_pk_busy;
        n_accept = i_valid && !o_stall;
        n_age = (r_age == 16'hFFFF) ? r_age : (r_age + 16'd1);
        n_pc = r_pc + 10'd1;
        n_decide = (n_pc >= r_period);
        n_fresh = r_seen && (n_age <= r_timeout);
        n_sfl = (!r_silent && r_sfl == 3'd0) ? rcfg_pkg::SAFE_FRAMES_CNT : r_sfl;

        n_thr_pos = !r_throttle[15] && (r_throttle != 16'd0);
        n_yaw_neg = r_yaw[15];
        n_yaw_abs = n_yaw_neg ? (~r_yaw + 16'd1) : r_yaw;
        n_yaw_coef = n_yaw_neg ? rcfg_pkg::COEF_YAW_NEG : rcfg_pkg::COEF_YAW_POS;

        n_fresh_chan[0] = button_axis(r_buttons[0], r_buttons[1]);
        n_fresh_chan[1] = button_axis(r_buttons[2], r_buttons[3]);
        n_fresh_chan[2] = n_thr_pos ? (rcfg_pkg::CH_MIN + w_thr_q) : rcfg_pkg::CH_MIN;
        n_fresh_chan[3] = n_yaw_neg ? (rcfg_pkg::CH_MID - w_yaw_q)
                                    : (rcfg_pkg::CH_MID + w_yaw_q);
        for (int i = 0; i < 3; i++) begin
            n_fresh_chan[4 + i] = r_latch[i] ? rcfg_pkg::CH_MAX : rcfg_pkg::CH_MIN;
        end

        n_safe_chan = {rcfg_pkg::NUM_VAR_CH{rcfg_pkg::CH_MIN}};
        n_safe_chan[0] = rcfg_pkg::CH_MID;
        n_safe_chan[1] = rcfg_pkg::CH_MID;
        n_safe_chan[3] = rcfg_pkg::CH_MID;
    end

    rcfg_scale u_thr_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_MUL_GO),
        .i_mag   (r_throttle[14:0]),
        .i_coef  (rcfg_pkg::COEF_THR),
        .o_quot  (w_thr_q),
        .o_done  (w_thr_done)
    );

    rcfg_scale u_yaw_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_MUL_GO),
        .i_mag   (n_yaw_abs[15:1]),
        .i_coef  (n_yaw_coef),
        .o_quot  (w_yaw_q),
        .o_done  (w_yaw_done)
    );

    rcfg_packer u_packer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_state == T_LAUNCH),
        .i_chan       (r_chan),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte),
        .o_busy       (w_pk_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 10'd10;
            r_timeout <= 16'd100;
            r_buttons <= '0;
            r_throttle <= '0;
            r_yaw <= '0;
            r_prev_latch <= '0;
            r_latch <= '0;
            r_seen <= 1'b0;
            r_link_lost <= 1'b1;
            r_age <= '0;
            r_pc <= '0;
            r_silent <= 1'b1;
            r_sfl <= '0;
            r_state <= T_IDLE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rcfg_pkg::CFG_OUTPUT_PERIOD:    r_period <= i_cfg_data[9:0];
                    rcfg_pkg::CFG_FAILSAFE_TIMEOUT: r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                T_IDLE: begin
                    if (n_accept && i_cmd == rcfg_pkg::CMD_CONTROL) begin
                        if (!r_seen || r_link_lost) begin
                            r_latch <= '0;
                            r_link_lost <= 1'b0;
                        end else begin
                            r_latch <= r_latch ^ (i_buttons[6:4] & ~r_prev_latch);
                        end
                        r_prev_latch <= i_buttons[6:4];
                        r_buttons <= i_buttons;
                        r_throttle <= i_throttle_axis;
                        r_yaw <= i_yaw_axis;
                        r_age <= '0;
                        r_seen <= 1'b1;
                    end else if (n_accept && i_cmd == rcfg_pkg::CMD_TICK) begin
                        r_age <= n_age;
                        if (!n_decide) begin
                            r_pc <= n_pc;
                        end else begin
                            r_pc <= '0;
                            if (n_fresh) begin
                                r_silent <= 1'b0;
                                r_sfl <= '0;
                                r_state <= T_MUL_GO;
                            end else begin
                                if (!r_silent && r_sfl == 3'd0) begin
                                    r_latch <= '0;
                                    r_link_lost <= 1'b1;
                                end
                                if (n_sfl != 3'd0) begin
                                    r_sfl <= n_sfl - 3'd1;
                                    if (n_sfl == 3'd1) begin
                                        r_silent <= 1'b1;
                                    end
                                    r_chan <= n_safe_chan;
                                    r_state <= T_LAUNCH;
                                end else begin
                                    r_sfl <= n_sfl;
                                end
                            end
                        end
                    end
                end
                T_MUL_GO: begin
                    r_state <= T_MUL_WAIT;
                end
                T_MUL_WAIT: begin
                    if (w_thr_done && w_yaw_done) begin
                        r_chan <= n_fresh_chan;
                        r_state <= T_LAUNCH;
                    end
                end
                T_LAUNCH: begin
                    r_state <= T_IDLE;
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_launch_idle_packer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_LAUNCH) |-> !w_pk_busy)
        else $error("frame launched while the packer was busy");
    a_safe_not_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sfl != 3'd0) |-> !r_silent)
        else $error("safe frames pending while silent");
    a_safe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sfl <= rcfg_pkg::SAFE_FRAMES_CNT)
        else $error("safe frame count out of range");
    a_scalers_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_thr_done == w_yaw_done)
        else $error("axis scalers finished apart");
`endif

endmodule

`default_nettype wire

FILE: dv/rcfg_frame_checker.sv
// Checker for the RC channel frame generator: tracks the control, timing and
// failsafe state, predicts every frame byte and compares it with the DUT output.
// Depends on rcfg_pkg for the frame constants and the command and register codes.
`default_nettype none

module rcfg_frame_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic        i_cmd,
    input  wire logic [6:0]  i_buttons,
    input  wire logic [15:0] i_throttle_axis,
    input  wire logic [15:0] i_yaw_axis,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [7:0]  i_frame_byte,
    input  wire logic        i_last_byte,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } t_frame_octet;

    t_frame_octet frame_fifo [$];
    t_frame_octet want;
    int           fail_total = 0;

    logic [9:0]  period_reg;
    logic [15:0] timeout_reg;
    logic [6:0]  held_btn;
    logic [15:0] held_thr;
    logic [15:0] held_yaw;
    logic [2:0]  prev_latch;
    logic [2:0]  toggles;
    logic        seen;
    logic        lost;
    logic [15:0] age;
    logic [9:0]  pcount;
    logic        quiet;
    logic [2:0]  safe_left;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
        fail_total++;
    endtask

    function automatic logic [10:0] axis_from_buttons(input logic lo, input logic hi);
        if (lo == hi) begin
            return rcfg_pkg::CH_MID;
        end
        return hi ? rcfg_pkg::CH_MID + rcfg_pkg::BTN_BIAS
                  : rcfg_pkg::CH_MID - rcfg_pkg::BTN_BIAS;
    endfunction

    function automatic logic [10:0] throttle_chan(input logic [15:0] raw);
        int x;
        x = $signed(raw);
        if (x <= 0) begin
            return rcfg_pkg::CH_MIN;
        end
        return 11'(172 + (x * 1639) / 32767);
    endfunction

    function automatic logic [10:0] yaw_chan(input logic [15:0] raw);
        int y;
        int s;
        y = $signed(raw);
        s = (y * 50) / 100;
        if (s > 32767) begin
            s = 32767;
        end
        if (s < -32767) begin
            s = -32767;
        end
        if (s >= 0) begin
            return 11'(992 + (s * 819) / 32767);
        end
        return 11'(992 + (s * 820) / 32767);
    endfunction

    function automatic logic [7:0] crc8_d5(input logic [7:0] acc, input logic [7:0] din);
        logic [7:0] r;
        r = acc ^ din;
        for (int k = 0; k < 8; k++) begin
            r = (r << 1) ^ (r[7] ? 8'hD5 : 8'h00);
        end
        return r;
    endfunction

    task automatic queue_frame(input logic [15:0][10:0] chans);
        logic [175:0] bits;
        logic [7:0]   octets [26];
        logic [7:0]   crc;
        t_frame_octet item;
        bits = chans;
        octets[0] = rcfg_pkg::BYTE_SYNC;
        octets[1] = rcfg_pkg::BYTE_LEN;
        octets[2] = rcfg_pkg::BYTE_TYPE;
        for (int k = 0; k < 22; k++) begin
            octets[3 + k] = bits[8 * k +: 8];
        end
        crc = 8'h00;
        for (int k = 2; k < 25; k++) begin
            crc = crc8_d5(crc, octets[k]);
        end
        octets[25] = crc;
        for (int k = 0; k < 26; k++) begin
            item.value = octets[k];
            item.is_last = (k == 25);
            frame_fifo.push_back(item);
        end
    endtask

    task automatic predict(input logic cmd, input logic [6:0] btn, input logic [15:0] thr,
                           input logic [15:0] yaw);
        logic [15:0][10:0] chans;
        logic [2:0]        lat;
        if (cmd == rcfg_pkg::CMD_CONTROL) begin
            lat = btn[6:4];
            if (!seen || lost) begin
                toggles = 3'b000;
                lost = 1'b0;
            end else begin
                toggles = toggles ^ (lat & ~prev_latch);
            end
            prev_latch = lat;
            held_btn = btn;
            held_thr = thr;
            held_yaw = yaw;
            age = 16'd0;
            seen = 1'b1;
            return;
        end

        if (age != 16'hFFFF) begin
            age = age + 16'd1;
        end
        pcount = pcount + 10'd1;
        if (pcount < period_reg) begin
            return;
        end
        pcount = 10'd0;

        for (int k = 0; k < 16; k++) begin
            chans[k] = rcfg_pkg::CH_MIN;
        end
        if (seen && age <= timeout_reg) begin
            chans[0] = axis_from_buttons(held_btn[0], held_btn[1]);
            chans[1] = axis_from_buttons(held_btn[2], held_btn[3]);
            chans[2] = throttle_chan(held_thr);
            chans[3] = yaw_chan(held_yaw);
            for (int k = 0; k < 3; k++) begin
                chans[4 + k] = toggles[k] ? rcfg_pkg::CH_MAX : rcfg_pkg::CH_MIN;
            end
            quiet = 1'b0;
            safe_left = 3'd0;
            queue_frame(chans);
            return;
        end

        if (!quiet && safe_left == 3'd0) begin
            toggles = 3'b000;
            lost = 1'b1;
            safe_left = 3'(rcfg_pkg::SAFE_FRAMES);
        end
        if (safe_left != 3'd0) begin
            chans[0] = rcfg_pkg::CH_MID;
            chans[1] = rcfg_pkg::CH_MID;
            chans[3] = rcfg_pkg::CH_MID;
            safe_left = safe_left - 3'd1;
            if (safe_left == 3'd0) begin
                quiet = 1'b1;
            end
            queue_frame(chans);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period_reg = 10'd10;
            timeout_reg = 16'd100;
            held_btn = '0;
            held_thr = '0;
            held_yaw = '0;
            prev_latch = '0;
            toggles = '0;
            seen = 1'b0;
            lost = 1'b1;
            age = '0;
            pcount = '0;
            quiet = 1'b1;
            safe_left = '0;
            frame_fifo.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frame_fifo.size() == 0) begin
                    report_mismatch("frame byte with nothing expected", i_frame_byte, 0);
                end else begin
                    want = frame_fifo.pop_front();
                    if (i_frame_byte !== want.value) begin
                        report_mismatch("frame byte", i_frame_byte, want.value);
                    end
                    if (i_last_byte !== want.is_last) begin
                        report_mismatch("last byte flag", i_last_byte, want.is_last);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rcfg_pkg::CFG_OUTPUT_PERIOD: period_reg = i_cfg_data[9:0];
                    rcfg_pkg::CFG_FAILSAFE_TIMEOUT: timeout_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict(i_cmd, i_buttons, i_throttle_axis, i_yaw_axis);
            end
        end
        o_pending <= frame_fifo.size();
        o_fail_count <= fail_total;
    end

endmodule

`default_nettype wire

FILE: dv/rc_channel_frame_generator_test.sv
// Testbench top for the RC channel frame generator: clock, reset, transaction
// stimulus, output stalls and the verdict. Depends on rcfg_pkg, the checker and the DUT.
`default_nettype none

module rc_channel_frame_generator_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        cmd;
    logic [6:0]  buttons;
    logic [15:0] throttle;
    logic [15:0] yaw;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        out_stall;
    logic        calm = 1'b0;
    wire logic   dut_stall;
    wire logic   out_valid;
    wire logic [7:0] frame_byte;
    wire logic   last_byte;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          cur_period = 10;
    int          cur_timeout = 100;

    rc_channel_frame_generator DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_stall         (dut_stall),
        .i_cmd           (cmd),
        .i_buttons       (buttons),
        .i_throttle_axis (throttle),
        .i_yaw_axis      (yaw),
        .o_valid         (out_valid),
        .i_stall         (out_stall),
        .o_frame_byte    (frame_byte),
        .o_last_byte     (last_byte),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    rcfg_frame_checker u_frame_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (dut_stall),
        .i_cmd           (cmd),
        .i_buttons       (buttons),
        .i_throttle_axis (throttle),
        .i_yaw_axis      (yaw),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_frame_byte    (frame_byte),
        .i_last_byte     (last_byte),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int ready_len;
        int stall_len;
        int r;
        out_stall = 1'b0;
        forever begin
            ready_len = $urandom_range(1, 12);
            repeat (ready_len) begin
                @(negedge clk);
                out_stall = 1'b0;
            end
            if (!calm) begin
                r = $urandom_range(0, 99);
                stall_len = (r < 70) ? $urandom_range(1, 3) :
                            (r < 95) ? $urandom_range(4, 10) : $urandom_range(20, 40);
                repeat (stall_len) begin
                    @(negedge clk);
                    out_stall = 1'b1;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [15:0] pick_axis();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return 16'h7FFF;
        end
        if (r < 30) begin
            return 16'h8000;
        end
        if (r < 38) begin
            return 16'h0000;
        end
        if (r < 41) begin
            return 16'h0001;
        end
        if (r < 44) begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    task automatic send_item(input logic c, input logic [6:0] b, input logic [15:0] t,
                             input logic [15:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd = c;
        buttons = b;
        throttle = t;
        yaw = y;
        in_valid = 1'b1;
        @(posedge clk);
        while (dut_stall) @(posedge clk);
    endtask

    task automatic control(input logic [6:0] b, input logic [15:0] t, input logic [15:0] y);
        send_item(rcfg_pkg::CMD_CONTROL, b, t, y);
    endtask

    task automatic tick();
        send_item(rcfg_pkg::CMD_TICK, 7'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(input logic [15:0] period_data, input logic [15:0] timeout);
        settle();
        write_reg(rcfg_pkg::CFG_OUTPUT_PERIOD, period_data);
        write_reg(rcfg_pkg::CFG_FAILSAFE_TIMEOUT, timeout);
        cur_period = period_data[9:0];
        cur_timeout = timeout;
    endtask

    task automatic random_phase(input int n_items);
        int done;
        int r;
        int k;
        int eff;
        int ticks;
        int short_max;
        done = 0;
        eff = (cur_period == 0) ? 1 : cur_period;
        short_max = ((cur_timeout < 3 * eff) ? cur_timeout : 3 * eff) + 1;
        while (done < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_item(1'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
                done++;
            end else begin
                k = $urandom_range(1, 3);
                if (k > n_items - done) begin
                    k = n_items - done;
                end
                repeat (k) control(7'($urandom_range(0, 127)), pick_axis(), pick_axis());
                if ($urandom_range(0, 99) < 60) begin
                    ticks = $urandom_range(1, short_max);
                end else begin
                    ticks = cur_timeout + (rcfg_pkg::SAFE_FRAMES + 2) * eff
                          + $urandom_range(0, 2 * eff);
                end
                if (ticks > n_items - done - k) begin
                    ticks = n_items - done - k;
                end
                repeat (ticks) tick();
                done += k + ticks;
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = rcfg_pkg::CMD_CONTROL;
        buttons = '0;
        throttle = '0;
        yaw = '0;
        cfg_we = 1'b0;
        cfg_index = rcfg_pkg::CFG_OUTPUT_PERIOD;
        cfg_data = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Register defaults; the first packet only samples the latch buttons.
        control(7'h7F, 16'h7FFF, 16'h8000);
        repeat (10) tick();

        configure(16'd1, 16'd2);
        control(7'h00, 16'h0000, 16'h0000);
        tick();
        control(7'h7F, 16'h7FFF, 16'h7FFF);
        tick();
        control(7'h05, 16'h8000, 16'h8000);
        tick();
        control(7'h0A, 16'h0001, 16'hFFFF);
        tick();
        control(7'h10, 16'hFFFF, 16'h0001);
        tick();
        repeat (8) tick();
        control(7'h70, 16'h7FFF, 16'h0000);
        tick();
        control(7'h00, 16'h4000, 16'hC000);
        control(7'h60, 16'h2000, 16'hE000);
        tick();

        configure(16'd0, 16'd1);
        random_phase(30);
        configure(16'd3, 16'd20);
        random_phase(60);
        configure(16'hFC02, 16'd0);
        random_phase(20);
        configure(16'd5, 16'd15);
        random_phase(70);
        calm = 1'b1;
        configure(16'd1, 16'd5);
        random_phase(40);

        // Period 1000, longest timeout; lowering the period below the count forces a decision.
        configure(16'd1000, 16'hFFFF);
        control(7'h3C, 16'h1234, 16'hEDCB);
        repeat (20) tick();
        settle();
        write_reg(rcfg_pkg::CFG_OUTPUT_PERIOD, 16'd5);
        cur_period = 5;
        tick();
        control(7'h50, 16'h0100, 16'hFF00);
        calm = 1'b0;
        configure(16'd4, 16'd12);
        random_phase(50);

        settle();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
sv/rcfg_pkg.sv
sv/rcfg_scale.sv
sv/rcfg_packer.sv
sv/rc_channel_frame_generator.sv
dv/rcfg_frame_checker.sv
dv/rc_channel_frame_generator_test.sv
